// ----- design/rth_pkg.sv -----
// rth_pkg: shared types and fixed constants for the RGB to HSL converter.
// No dependencies; imported by rth_front and rgb_to_hsl_core.
`timescale 1ns / 1ps

package rth_pkg;

  // Result field widths (fixed by the output format).
  localparam int unsigned HUE_W    = 15;
  localparam int unsigned SAT_W    = 16;
  localparam int unsigned LIGHT_W  = 9;
  localparam int unsigned CHROMA_W = 8;

  // Both divider lanes produce this many quotient bits, one per stage.
  localparam int unsigned QUO_W = 16;

  // One hue sector is 60 degrees in 1/64 degree = 3840 = 4096 - 256.
  localparam int unsigned HUE_SECTOR    = 3840;
  localparam int unsigned HUE_FULL      = 23040;
  localparam int unsigned HUE_SHIFT_HI  = 12;
  localparam int unsigned HUE_SHIFT_LO  = 8;

  // Per-pixel control that travels beside the datapath.
  typedef struct packed {
    logic valid;
    logic grey;
  } rth_ctrl_t;

endpackage

// ----- design/rgb_to_hsl_core.sv -----
// Pipeline: 4 front stages, 16 divider stages and 1 output register lie between the
// start_i edge and the valid_o cycle.
// Throughput: one pixel per clock; busy_o never rises, since the receiver cannot stall.
// The quotient pipelines have 16 stages, one quotient bit per stage.
// Reset: rst_ni is asynchronous, active low; it clears every valid bit, no result follows.
`timescale 1ns / 1ps

module rgb_to_hsl_core import rth_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [CHANNEL_BITS-1:0] red_in_i,
  input  logic [CHANNEL_BITS-1:0] green_in_i,
  input  logic [CHANNEL_BITS-1:0] blue_in_i,
  output logic                    valid_o,
  output logic [HUE_W-1:0]        hue_out_o,
  output logic [SAT_W-1:0]        sat_out_o,
  output logic [LIGHT_W-1:0]      light_out_o,
  output logic [CHROMA_W-1:0]     chroma_out_o
);

  localparam int unsigned CB      = CHANNEL_BITS;
  localparam int unsigned SIDE_W  = 2 * CB + 1;   // {light, chroma}
  localparam int unsigned LATENCY = 4 + QUO_W + 1;

  // Every stage advances every cycle, so a new transaction is always taken.
  assign busy_o = 1'b0;

  // Front end: pixel in, numerators and divisor out.
  rth_ctrl_t              front_ctrl;
  logic [CB+QUO_W-1:0]    hue_num, sat_num;
  logic [CB-1:0]          den, chroma;
  logic [CB:0]            light;

  rth_front #(
    .CHANNEL_BITS(CB)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .red_i    (red_in_i),
    .green_i  (green_in_i),
    .blue_i   (blue_in_i),
    .ctrl_o   (front_ctrl),
    .hue_num_o(hue_num),
    .sat_num_o(sat_num),
    .den_o    (den),
    .chroma_o (chroma),
    .light_o  (light)
  );

  // Hue lane: angle * 3840 / chroma; the grey flag rides along.
  logic             hue_valid;
  logic [QUO_W-1:0] hue_quo;
  logic             hue_grey;

  rth_div_pipe #(
    .DW(CB),
    .QW(QUO_W),
    .SW(1)
  ) u_hue_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(front_ctrl.valid),
    .num_i  (hue_num),
    .den_i  (chroma),
    .side_i (front_ctrl.grey),
    .valid_o(hue_valid),
    .quo_o  (hue_quo),
    .side_o (hue_grey)
  );

  // Saturation lane: chroma * 65535 / (M - |light - M|); light and chroma ride along.
  logic              sat_valid;
  logic [QUO_W-1:0]  sat_quo;
  logic [SIDE_W-1:0] sat_side;

  rth_div_pipe #(
    .DW(CB),
    .QW(QUO_W),
    .SW(SIDE_W)
  ) u_sat_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(front_ctrl.valid),
    .num_i  (sat_num),
    .den_i  (den),
    .side_i ({light, chroma}),
    .valid_o(sat_valid),
    .quo_o  (sat_quo),
    .side_o (sat_side)
  );

  // Output register: drop the quotients of a grey pixel (divisor zero).
  logic                valid_q;
  logic [HUE_W-1:0]    hue_q;
  logic [SAT_W-1:0]    sat_q;
  logic [LIGHT_W-1:0]  light_q;
  logic [CHROMA_W-1:0] chroma_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= sat_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q    <= hue_grey ? '0 : hue_quo[HUE_W-1:0];
    sat_q    <= hue_grey ? '0 : SAT_W'(sat_quo);
    light_q  <= LIGHT_W'(sat_side[SIDE_W-1:CB]);
    chroma_q <= CHROMA_W'(sat_side[CB-1:0]);
  end

  assign valid_o      = valid_q;
  assign hue_out_o    = hue_q;
  assign sat_out_o    = sat_q;
  assign light_out_o  = light_q;
  assign chroma_out_o = chroma_q;

`ifndef SYNTHESIS
  // Both division lanes must stay in lockstep.
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hue_valid == sat_valid)
    else $error("hue and saturation lanes out of step");

  // Every accepted transaction yields a result after the pipeline depth.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY valid_o)
    else $error("result missing after accepted transaction");

  // Wrapped hue stays below a full turn.
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hue_out_o < HUE_W'(HUE_FULL)))
    else $error("hue out of range");

  // A grey pixel carries zero hue and zero saturation.
  a_grey_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && chroma_out_o == '0 && CB <= CHROMA_W) |-> (hue_out_o == '0 && sat_out_o == '0))
    else $error("grey pixel with nonzero hue or saturation");
`endif

endmodule

// ----- design/rth_front.sv -----
// rth_front: input register, max/min and sector select, then numerator and
// divisor formation for the hue and saturation divisions. Uses rth_pkg.
`timescale 1ns / 1ps

module rth_front import rth_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [CHANNEL_BITS-1:0]          red_i,
  input  logic [CHANNEL_BITS-1:0]          green_i,
  input  logic [CHANNEL_BITS-1:0]          blue_i,
  output rth_ctrl_t                        ctrl_o,
  output logic [CHANNEL_BITS+QUO_W-1:0]    hue_num_o,
  output logic [CHANNEL_BITS+QUO_W-1:0]    sat_num_o,
  output logic [CHANNEL_BITS-1:0]          den_o,
  output logic [CHANNEL_BITS-1:0]          chroma_o,
  output logic [CHANNEL_BITS:0]            light_o
);

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned SW = CB + 4;       // signed hue angle width
  localparam int unsigned NW = CB + QUO_W;   // numerator width

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // Stage A: captured pixel.
  logic          a_val_q;
  logic [CB-1:0] a_r_q, a_g_q, a_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_val_q <= 1'b0;
    end else begin
      a_val_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_r_q <= red_i;
    a_g_q <= green_i;
    a_b_q <= blue_i;
  end

  // Stage B: extremes and sector.
  logic [CB-1:0] b_mx_d, b_mn_d;
  sector_e       b_sec_d;
  logic          b_val_q;
  logic [CB-1:0] b_r_q, b_g_q, b_b_q, b_mx_q, b_mn_q;
  sector_e       b_sec_q;

  always_comb begin
    b_mx_d = a_r_q;
    b_mn_d = a_r_q;
    if (a_g_q > b_mx_d) b_mx_d = a_g_q;
    if (a_b_q > b_mx_d) b_mx_d = a_b_q;
    if (a_g_q < b_mn_d) b_mn_d = a_g_q;
    if (a_b_q < b_mn_d) b_mn_d = a_b_q;
    // Ties go to red first, then green.
    if (a_r_q >= a_g_q && a_r_q >= a_b_q) begin
      b_sec_d = SEC_RED;
    end else if (a_g_q >= a_b_q) begin
      b_sec_d = SEC_GREEN;
    end else begin
      b_sec_d = SEC_BLUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_val_q <= 1'b0;
    end else begin
      b_val_q <= a_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_r_q   <= a_r_q;
    b_g_q   <= a_g_q;
    b_b_q   <= a_b_q;
    b_mx_q  <= b_mx_d;
    b_mn_q  <= b_mn_d;
    b_sec_q <= b_sec_d;
  end

  // Stage C: chroma, lightness, wrapped hue angle in sector units, divisor.
  logic [CB-1:0]        c_chroma_d;
  logic [CB:0]          c_light_d;
  logic signed [SW-1:0] c_diff;
  logic signed [SW-1:0] c_angle;
  logic [SW-1:0]        c_six;
  logic [CB+2:0]        c_ang_d;
  logic [CB-1:0]        c_den_d;
  logic                 c_val_q, c_grey_q;
  logic [CB-1:0]        c_chroma_q, c_den_q;
  logic [CB:0]          c_light_q;
  logic [CB+2:0]        c_ang_q;

  always_comb begin
    c_chroma_d = b_mx_q - b_mn_q;
    c_light_d  = {1'b0, b_mx_q} + {1'b0, b_mn_q};
    c_six      = {3'b000, c_chroma_d, 1'b0} + {2'b00, c_chroma_d, 2'b00};
    case (b_sec_q)
      SEC_RED: begin
        c_diff = $signed({4'b0000, b_g_q}) - $signed({4'b0000, b_b_q});
      end
      SEC_GREEN: begin
        c_diff = $signed({4'b0000, b_b_q}) - $signed({4'b0000, b_r_q})
               + $signed({3'b000, c_chroma_d, 1'b0});
      end
      SEC_BLUE: begin
        c_diff = $signed({4'b0000, b_r_q}) - $signed({4'b0000, b_g_q})
               + $signed({2'b00, c_chroma_d, 2'b00});
      end
      default: begin
        c_diff = '0;
      end
    endcase
    // Wrap a negative angle by a full turn (six sectors).
    c_angle = c_diff[SW-1] ? (c_diff + $signed(c_six)) : c_diff;
    c_ang_d = c_angle[CB+2:0];
    if (c_light_d >= {1'b0, {CB{1'b1}}}) begin
      c_den_d = CB'({{CB{1'b1}}, 1'b0} - c_light_d);
    end else begin
      c_den_d = c_light_d[CB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_val_q <= 1'b0;
    end else begin
      c_val_q <= b_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_grey_q   <= (c_chroma_d == '0);
    c_chroma_q <= c_chroma_d;
    c_light_q  <= c_light_d;
    c_ang_q    <= c_ang_d;
    c_den_q    <= c_den_d;
  end

  // Stage D: scaled numerators by shift and subtract.
  logic          d_val_q, d_grey_q;
  logic [NW-1:0] d_hue_num_q, d_sat_num_q;
  logic [CB-1:0] d_den_q, d_chroma_q;
  logic [CB:0]   d_light_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_val_q <= 1'b0;
    end else begin
      d_val_q <= c_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_grey_q    <= c_grey_q;
    d_hue_num_q <= (NW'(c_ang_q) << HUE_SHIFT_HI) - (NW'(c_ang_q) << HUE_SHIFT_LO);
    d_sat_num_q <= {c_chroma_q, QUO_W'(0)} - NW'(c_chroma_q);
    d_den_q     <= c_den_q;
    d_chroma_q  <= c_chroma_q;
    d_light_q   <= c_light_q;
  end

  assign ctrl_o.valid = d_val_q;
  assign ctrl_o.grey  = d_grey_q;
  assign hue_num_o    = d_hue_num_q;
  assign sat_num_o    = d_sat_num_q;
  assign den_o        = d_den_q;
  assign chroma_o     = d_chroma_q;
  assign light_o      = d_light_q;

endmodule

// ----- design/rth_div_pipe.sv -----
// rth_div_pipe: pipelined restoring divider, one quotient bit per stage,
// with a side payload carried alongside. No package dependencies.
`timescale 1ns / 1ps

module rth_div_pipe #(
  parameter int unsigned DW = 8,
  parameter int unsigned QW = 16,
  parameter int unsigned SW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [DW+QW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [QW-1:0]    quo_o,
  output logic [SW-1:0]    side_o
);

  localparam int unsigned RW = DW + QW;

  // Requires num_i < den_i * 2**QW; the quotient then fits in QW bits.
  logic          val_q  [1:QW];
  logic [RW-1:0] rem_q  [1:QW];
  logic [QW-1:0] quo_q  [1:QW];
  logic [DW-1:0] den_q  [1:QW];
  logic [SW-1:0] side_q [1:QW];

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int unsigned SH = QW - k;
    logic          val_in;
    logic [RW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [RW-1:0] trial;
    logic          take;

    if (k == 1) begin : g_first
      assign val_in  = valid_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign val_in  = val_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = RW'(den_in) << SH;
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_q[k] <= 1'b0;
      end else begin
        val_q[k] <= val_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]     <= take ? (rem_in - trial) : rem_in;
      quo_q[k]     <= quo_in | (QW'(take) << SH);
      den_q[k]     <= den_in;
      side_q[k]    <= side_in;
    end
  end

  assign valid_o = val_q[QW];
  assign quo_o   = quo_q[QW];
  assign side_o  = side_q[QW];

endmodule
